// ===== src/mer_pkg.sv =====
package mer_pkg;

    localparam int RADIUS_BITS_DEF = 10;
    localparam int COORD_BITS_DEF  = 11;

    // result coordinates wrap to this width
    localparam int PIX_W = 13;

    // pixels per step group
    localparam int GROUP_LEN = 4;

    // item queue between the front and the engine
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

endpackage

// ===== src/midpoint_ellipse_rasterizer_core.sv =====
// Midpoint ellipse rasterizer. Items enter through start/busy into a two-entry queue, so the
// block keeps taking items while the engine works; busy rises only when the queue is full.
// A start item (op = 0) runs in the engine as three squarings and products on one shared
// multiplier, then two adds, and goes on into the region-two setup when a zero radius sends
// it straight into region two. A step item (op = 1) runs a point update, a region check that
// waits while the emitter is busy, then three decision adds that overlap a burst of four
// back-to-back pixels, each marked by pixel_strobe, last_of_step on the fourth. A step that
// crosses into region two adds multiplier work (states S_R1 to S_R6) for the new decision
// value. A step with no ellipse running is popped and dropped. Results cannot be held off:
// the receiver must take each pixel in the cycle it is shown.
module midpoint_ellipse_rasterizer_core
    import mer_pkg::*;
#(
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    op,
    input  logic [RADIUS_BITS-1:0]  semi_axis_x,
    input  logic [RADIUS_BITS-1:0]  semi_axis_y,
    input  logic [COORD_BITS-1:0]   center_x,
    input  logic [COORD_BITS-1:0]   center_y,
    output logic                    pixel_strobe,
    output logic signed [PIX_W-1:0] pixel_x,
    output logic signed [PIX_W-1:0] pixel_y,
    output logic                    last_of_step,
    output logic                    ellipse_done
);

    logic                          item_valid;
    logic                          item_op;
    logic [RADIUS_BITS-1:0]        item_rx;
    logic [RADIUS_BITS-1:0]        item_ry;
    logic [COORD_BITS-1:0]         item_cx;
    logic [COORD_BITS-1:0]         item_cy;
    logic                          item_pop;
    logic                          emit_busy;
    logic                          launch;
    logic [RADIUS_BITS:0]          emit_x;
    logic signed [RADIUS_BITS+1:0] emit_y;
    logic [COORD_BITS-1:0]         emit_cx;
    logic [COORD_BITS-1:0]         emit_cy;
    logic                          emit_done;

    mer_front #(
        .RADIUS_BITS(RADIUS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .semi_axis_x(semi_axis_x),
        .semi_axis_y(semi_axis_y),
        .center_x   (center_x),
        .center_y   (center_y),
        .item_valid (item_valid),
        .item_op    (item_op),
        .item_rx    (item_rx),
        .item_ry    (item_ry),
        .item_cx    (item_cx),
        .item_cy    (item_cy),
        .item_pop   (item_pop)
    );

    mer_engine #(
        .RADIUS_BITS(RADIUS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_op   (item_op),
        .item_rx   (item_rx),
        .item_ry   (item_ry),
        .item_cx   (item_cx),
        .item_cy   (item_cy),
        .item_pop  (item_pop),
        .emit_busy (emit_busy),
        .launch    (launch),
        .emit_x    (emit_x),
        .emit_y    (emit_y),
        .emit_cx   (emit_cx),
        .emit_cy   (emit_cy),
        .emit_done (emit_done)
    );

    mer_emit #(
        .RADIUS_BITS(RADIUS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .launch      (launch),
        .emit_x      (emit_x),
        .emit_y      (emit_y),
        .emit_cx     (emit_cx),
        .emit_cy     (emit_cy),
        .emit_done   (emit_done),
        .emit_busy   (emit_busy),
        .pixel_strobe(pixel_strobe),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .last_of_step(last_of_step),
        .ellipse_done(ellipse_done)
    );

endmodule

// ===== src/mer_front.sv =====
module mer_front
    import mer_pkg::*;
#(
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   op,
    input  logic [RADIUS_BITS-1:0] semi_axis_x,
    input  logic [RADIUS_BITS-1:0] semi_axis_y,
    input  logic [COORD_BITS-1:0]  center_x,
    input  logic [COORD_BITS-1:0]  center_y,
    output logic                   item_valid,
    output logic                   item_op,
    output logic [RADIUS_BITS-1:0] item_rx,
    output logic [RADIUS_BITS-1:0] item_ry,
    output logic [COORD_BITS-1:0]  item_cx,
    output logic [COORD_BITS-1:0]  item_cy,
    input  logic                   item_pop
);

    localparam int ITEM_W = 1 + 2 * RADIUS_BITS + 2 * COORD_BITS;
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    logic [ITEM_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              pop;
    logic [ITEM_W-1:0] head;

    assign busy       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign push       = start && !busy;
    assign pop        = item_pop && item_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= {op, semi_axis_x, semi_axis_y, center_x, center_y};
        end
    end

    assign head = entry_reg[rd_ptr_reg];
    assign {item_op, item_rx, item_ry, item_cx, item_cy} = head;

endmodule

// ===== src/mer_mult.sv =====
module mer_mult #(
    parameter int W = 24
) (
    input  logic           clk,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] p
);

    logic [2*W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= (2 * W)'(a) * (2 * W)'(b);
    end

    assign p = p_reg;

endmodule

// ===== src/mer_engine.sv =====
module mer_engine
    import mer_pkg::*;
#(
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_op,
    input  logic [RADIUS_BITS-1:0]        item_rx,
    input  logic [RADIUS_BITS-1:0]        item_ry,
    input  logic [COORD_BITS-1:0]         item_cx,
    input  logic [COORD_BITS-1:0]         item_cy,
    output logic                          item_pop,
    input  logic                          emit_busy,
    output logic                          launch,
    output logic [RADIUS_BITS:0]          emit_x,
    output logic signed [RADIUS_BITS+1:0] emit_y,
    output logic [COORD_BITS-1:0]         emit_cx,
    output logic [COORD_BITS-1:0]         emit_cy,
    output logic                          emit_done
);

    localparam int X_W   = RADIUS_BITS + 1;
    localparam int Y_W   = RADIUS_BITS + 2;
    localparam int SQ_W  = 2 * RADIUS_BITS;
    localparam int G_W   = 3 * RADIUS_BITS + 10;
    localparam int MUL_W = 2 * RADIUS_BITS + 4;
    localparam int P_W   = 2 * MUL_W;
    localparam int D_W   = P_W + 1;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_UPD  = 5'd1;
    localparam logic [4:0] S_CHK  = 5'd2;
    localparam logic [4:0] S_ADD1 = 5'd3;
    localparam logic [4:0] S_ADD2 = 5'd4;
    localparam logic [4:0] S_ADD3 = 5'd5;
    localparam logic [4:0] S_M1   = 5'd6;
    localparam logic [4:0] S_M2   = 5'd7;
    localparam logic [4:0] S_M3   = 5'd8;
    localparam logic [4:0] S_M4   = 5'd9;
    localparam logic [4:0] S_M5   = 5'd10;
    localparam logic [4:0] S_R1   = 5'd11;
    localparam logic [4:0] S_R2   = 5'd12;
    localparam logic [4:0] S_R3   = 5'd13;
    localparam logic [4:0] S_R4   = 5'd14;
    localparam logic [4:0] S_R5   = 5'd15;
    localparam logic [4:0] S_R6   = 5'd16;

    logic [4:0] state_reg, state_next;
    logic       active_reg, active_next;
    logic       region_reg, region_next;
    logic       sw_reg, sw_next;
    logic       t1_reg, t1_next;
    logic       t2_reg, t2_next;
    logic       krx_reg, krx_next;

    logic [X_W-1:0]         x_reg, x_next;
    logic signed [Y_W-1:0]  y_reg, y_next;
    logic [X_W-1:0]         ox_reg, ox_next;
    logic signed [Y_W-1:0]  oy_reg, oy_next;
    logic signed [G_W-1:0]  gx_reg, gx_next;
    logic signed [G_W-1:0]  gy_reg, gy_next;
    logic signed [D_W-1:0]  d_reg, d_next;
    logic [RADIUS_BITS-1:0] rx_reg, rx_next;
    logic [RADIUS_BITS-1:0] ry_reg, ry_next;
    logic [COORD_BITS-1:0]  cx_reg, cx_next;
    logic [COORD_BITS-1:0]  cy_reg, cy_next;
    logic [SQ_W-1:0]        rx2_reg, rx2_next;
    logic [SQ_W-1:0]        ry2_reg, ry2_next;
    logic [MUL_W-1:0]       tmp_reg, tmp_next;

    logic [MUL_W-1:0]      mul_a;
    logic [MUL_W-1:0]      mul_b;
    logic [P_W-1:0]        mul_p;

    logic signed [G_W-1:0] gx_step;
    logic signed [G_W-1:0] gy_step;
    logic signed [D_W-1:0] gx_d;
    logic signed [D_W-1:0] gy_d;
    logic signed [D_W-1:0] k_d;
    logic signed [D_W-1:0] p_d;
    logic                  d_neg;
    logic                  d_pos;
    logic                  gx_lt_gy;
    logic                  sw;
    logic                  fin;
    logic signed [Y_W:0]   ty;
    logic [Y_W:0]          ty_abs;
    logic [X_W:0]          tx;

    mer_mult #(
        .W(MUL_W)
    ) u_mult (
        .clk(clk),
        .a  (mul_a),
        .b  (mul_b),
        .p  (mul_p)
    );

    assign gx_step  = gx_reg + G_W'({rx2_reg[0] & 1'b0, ry2_reg, 1'b0});
    assign gy_step  = gy_reg - G_W'({1'b0, rx2_reg, 1'b0});
    assign gx_d     = D_W'(gx_reg);
    assign gy_d     = D_W'(gy_reg);
    assign k_d      = $signed(D_W'({krx_reg ? rx2_reg : ry2_reg, 2'b00}));
    assign p_d      = $signed(D_W'(mul_p));
    assign d_neg    = d_reg[D_W-1];
    assign d_pos    = !d_neg && (d_reg != '0);
    assign gx_lt_gy = (gx_reg < gy_reg);
    // region switch and end of ellipse, seen on the freshly updated point
    assign sw       = !region_reg && !gx_lt_gy;
    assign fin      = (region_reg || sw) && y_reg[Y_W-1];
    assign ty       = (Y_W + 1)'(y_reg) - (Y_W + 1)'(1);
    assign ty_abs   = ty[Y_W] ? -ty : ty;
    assign tx       = {x_reg, 1'b1};

    assign emit_x    = ox_reg;
    assign emit_y    = oy_reg;
    assign emit_cx   = cx_reg;
    assign emit_cy   = cy_reg;
    assign emit_done = fin;

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        region_next = region_reg;
        sw_next     = sw_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        krx_next    = krx_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        gx_next     = gx_reg;
        gy_next     = gy_reg;
        d_next      = d_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        rx2_next    = rx2_reg;
        ry2_next    = ry2_reg;
        tmp_next    = tmp_reg;
        mul_a       = '0;
        mul_b       = '0;
        item_pop    = 1'b0;
        launch      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    if (item_op == OP_START)
                    begin
                        rx_next     = item_rx;
                        ry_next     = item_ry;
                        cx_next     = item_cx;
                        cy_next     = item_cy;
                        x_next      = '0;
                        y_next      = Y_W'(item_ry);
                        gx_next     = '0;
                        region_next = 1'b0;
                        active_next = 1'b1;
                        state_next  = S_M1;
                    end
                    else if (item_op == OP_STEP && active_reg)
                    begin
                        ox_next    = x_reg;
                        oy_next    = y_reg;
                        state_next = S_UPD;
                    end
                end
            end

            S_UPD:
            begin
                if (!region_reg)
                begin
                    x_next   = x_reg + X_W'(1);
                    gx_next  = gx_step;
                    krx_next = 1'b0;
                    t1_next  = 1'b1;
                    t2_next  = !d_neg;
                    if (!d_neg)
                    begin
                        y_next  = y_reg - Y_W'(1);
                        gy_next = gy_step;
                    end
                end
                else
                begin
                    y_next   = y_reg - Y_W'(1);
                    gy_next  = gy_step;
                    krx_next = 1'b1;
                    t2_next  = 1'b1;
                    t1_next  = !d_pos;
                    if (!d_pos)
                    begin
                        x_next  = x_reg + X_W'(1);
                        gx_next = gx_step;
                    end
                end
                state_next = S_CHK;
            end

            S_CHK:
            begin
                if (!emit_busy)
                begin
                    launch  = 1'b1;
                    sw_next = sw;
                    if (fin)
                    begin
                        active_next = 1'b0;
                    end
                    state_next = S_ADD1;
                end
            end

            // decision update spread over three adds, in parallel with the pixel burst
            S_ADD1:
            begin
                if (t1_reg)
                begin
                    d_next = d_reg + (gx_d <<< 2);
                end
                state_next = S_ADD2;
            end

            S_ADD2:
            begin
                if (t2_reg)
                begin
                    d_next = d_reg - (gy_d <<< 2);
                end
                state_next = S_ADD3;
            end

            S_ADD3:
            begin
                d_next     = d_reg + k_d;
                state_next = sw_reg ? S_R1 : S_IDLE;
            end

            S_M1:
            begin
                mul_a      = MUL_W'(rx_reg);
                mul_b      = MUL_W'(rx_reg);
                state_next = S_M2;
            end

            S_M2:
            begin
                rx2_next   = mul_p[SQ_W-1:0];
                mul_a      = MUL_W'(ry_reg);
                mul_b      = MUL_W'(ry_reg);
                state_next = S_M3;
            end

            S_M3:
            begin
                ry2_next   = mul_p[SQ_W-1:0];
                mul_a      = MUL_W'(rx2_reg);
                mul_b      = MUL_W'(ry_reg);
                state_next = S_M4;
            end

            S_M4:
            begin
                // grad_y = 2*rx^2*ry; decision starts at 4*ry^2 + rx^2
                gy_next    = $signed(G_W'(mul_p)) <<< 1;
                d_next     = $signed(D_W'({ry2_reg, 2'b00})) + $signed(D_W'(rx2_reg));
                state_next = S_M5;
            end

            S_M5:
            begin
                d_next     = d_reg - (gy_d <<< 1);
                state_next = gx_lt_gy ? S_IDLE : S_R1;
            end

            // region-two entry: ry2*(2x+1)^2 + 4*rx2*(y-1)^2 - 4*rx2*ry2
            S_R1:
            begin
                mul_a      = MUL_W'(tx);
                mul_b      = MUL_W'(tx);
                state_next = S_R2;
            end

            S_R2:
            begin
                tmp_next   = mul_p[MUL_W-1:0];
                mul_a      = MUL_W'(ty_abs);
                mul_b      = MUL_W'(ty_abs);
                state_next = S_R3;
            end

            S_R3:
            begin
                tmp_next   = mul_p[MUL_W-1:0];
                mul_a      = MUL_W'(ry2_reg);
                mul_b      = tmp_reg;
                state_next = S_R4;
            end

            S_R4:
            begin
                d_next     = p_d;
                mul_a      = MUL_W'(rx2_reg);
                mul_b      = tmp_reg;
                state_next = S_R5;
            end

            S_R5:
            begin
                d_next     = d_reg + (p_d <<< 2);
                mul_a      = MUL_W'(rx2_reg);
                mul_b      = MUL_W'(ry2_reg);
                state_next = S_R6;
            end

            S_R6:
            begin
                d_next      = d_reg - (p_d <<< 2);
                region_next = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= 1'b0;
            region_reg <= 1'b0;
            sw_reg     <= 1'b0;
            t1_reg     <= 1'b0;
            t2_reg     <= 1'b0;
            krx_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            region_reg <= region_next;
            sw_reg     <= sw_next;
            t1_reg     <= t1_next;
            t2_reg     <= t2_next;
            krx_reg    <= krx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        ox_reg  <= ox_next;
        oy_reg  <= oy_next;
        gx_reg  <= gx_next;
        gy_reg  <= gy_next;
        d_reg   <= d_next;
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        rx2_reg <= rx2_next;
        ry2_reg <= ry2_next;
        tmp_reg <= tmp_next;
    end

endmodule

// ===== src/mer_emit.sv =====
module mer_emit
    import mer_pkg::*;
#(
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          launch,
    input  logic [RADIUS_BITS:0]          emit_x,
    input  logic signed [RADIUS_BITS+1:0] emit_y,
    input  logic [COORD_BITS-1:0]         emit_cx,
    input  logic [COORD_BITS-1:0]         emit_cy,
    input  logic                          emit_done,
    output logic                          emit_busy,
    output logic                          pixel_strobe,
    output logic signed [PIX_W-1:0]       pixel_x,
    output logic signed [PIX_W-1:0]       pixel_y,
    output logic                          last_of_step,
    output logic                          ellipse_done
);

    localparam int X_W    = RADIUS_BITS + 1;
    localparam int Y_W    = RADIUS_BITS + 2;
    localparam int CNT_W  = $clog2(GROUP_LEN);
    localparam int MAX_A  = (COORD_BITS > Y_W) ? COORD_BITS : Y_W;
    localparam int SUM_W  = ((MAX_A > PIX_W) ? MAX_A : PIX_W) + 1;

    logic                  run_reg, run_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [X_W-1:0]        x_reg;
    logic signed [Y_W-1:0] y_reg;
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;
    logic                  done_reg;
    logic                  is_last;
    logic [SUM_W-1:0]      x_e;
    logic [SUM_W-1:0]      y_e;
    logic [SUM_W-1:0]      sum_x;
    logic [SUM_W-1:0]      sum_y;

    assign is_last = (cnt_reg == CNT_W'(GROUP_LEN - 1));

    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        if (run_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (is_last)
            begin
                run_next = 1'b0;
            end
        end
        else if (launch)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch && !run_reg)
        begin
            x_reg    <= emit_x;
            y_reg    <= emit_y;
            cx_reg   <= emit_cx;
            cy_reg   <= emit_cy;
            done_reg <= emit_done;
        end
    end

    // order: (+x,+y), (-x,+y), (+x,-y), (-x,-y)
    assign x_e   = SUM_W'(x_reg);
    assign y_e   = SUM_W'(y_reg);
    assign sum_x = SUM_W'(cx_reg) + (cnt_reg[0] ? -x_e : x_e);
    assign sum_y = SUM_W'(cy_reg) + (cnt_reg[1] ? -y_e : y_e);

    assign emit_busy    = run_reg;
    assign pixel_strobe = run_reg;
    assign pixel_x      = $signed(sum_x[PIX_W-1:0]);
    assign pixel_y      = $signed(sum_y[PIX_W-1:0]);
    assign last_of_step = run_reg && is_last;
    assign ellipse_done = run_reg && done_reg;

endmodule

// ===== src/mer_checker.sv =====
module mer_checker (
    input logic clk,
    input logic rst_n,
    input logic pixel_strobe,
    input logic last_of_step,
    input logic ellipse_done
);

    // a group is four back-to-back transfers
    a_group_runs: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_strobe && !last_of_step |=> pixel_strobe)
        else $error("pixel group broken before its last transfer");

    // groups never abut: the emitter starts a new burst only from idle
    a_group_gap: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_strobe && last_of_step |=> !pixel_strobe)
        else $error("new pixel group directly after a last transfer");

    a_done_steady: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_strobe && !last_of_step |=> $stable(ellipse_done))
        else $error("ellipse_done changed inside a group");

    a_group_len: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_strobe && last_of_step |-> $past(pixel_strobe, 3))
        else $error("last transfer without three before it");

    a_flags_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_strobe |-> !last_of_step && !ellipse_done)
        else $error("result flags set with no transfer");

endmodule

bind midpoint_ellipse_rasterizer_core mer_checker u_mer_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_strobe(pixel_strobe),
    .last_of_step(last_of_step),
    .ellipse_done(ellipse_done)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import mer_pkg::*;

    localparam int RB = RADIUS_BITS_DEF;
    localparam int CB = COORD_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int DIR_ROWS = 25;
    localparam int TOTAL_ITEMS = 420;

    typedef struct packed {
        logic          op;
        logic [RB-1:0] rx;
        logic [RB-1:0] ry;
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic          typed;    // expected group given in the row itself
        logic [2:0]    n_typed;
        logic [PIX_W-1:0] tx;
        logic [PIX_W-1:0] ty;
        logic          tdone;
    } stim_row_t;

    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic             last;
        logic             done;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    stim_row_t drv = '0;

    logic busy;
    logic pixel_strobe;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic last_of_step;
    logic ellipse_done;

    midpoint_ellipse_rasterizer_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (drv.op),
        .semi_axis_x  (drv.rx),
        .semi_axis_y  (drv.ry),
        .center_x     (drv.cx),
        .center_y     (drv.cy),
        .pixel_strobe (pixel_strobe),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .last_of_step (last_of_step),
        .ellipse_done (ellipse_done)
    );

    always #5 clk = ~clk;

    // shadow ellipse state, decision values scaled by 4
    logic   ell_active = 1'b0;
    logic   ell_region2 = 1'b0;
    longint ell_x = 0;
    longint ell_y = 0;
    longint ell_dec = 0;
    longint ell_gx = 0;
    longint ell_gy = 0;
    longint ell_rx = 0;
    longint ell_ry = 0;
    longint ell_cx = 0;
    longint ell_cy = 0;

    pixel_t group_buf [0:3];
    int     group_len;
    pixel_t pixels_due [$];

    int mismatches = 0;
    int stall_cycles = 0;
    int items_sent = 0;
    int calm_left = 0;

    stim_row_t dir_tab [0:DIR_ROWS-1];

    task automatic check_region_switch();
        longint tx2;
        longint ty1;
        if (!ell_region2 && !(ell_gx < ell_gy)) begin
            tx2 = 2 * ell_x + 1;
            ty1 = ell_y - 1;
            ell_region2 = 1'b1;
            ell_dec = ell_ry * ell_ry * tx2 * tx2 + 4 * ell_rx * ell_rx * ty1 * ty1
                    - 4 * ell_rx * ell_rx * ell_ry * ell_ry;
        end
        if (ell_region2 && ell_y < 0)
            ell_active = 1'b0;
    endtask

    // fills group_buf with the pixels one item produces
    task automatic trace_ellipse(input stim_row_t r);
        longint rx2;
        longint ry2;
        longint x0;
        longint y0;
        longint sx [0:3];
        longint sy [0:3];
        group_len = 0;
        if (r.op == OP_START) begin
            ell_rx = longint'(r.rx);
            ell_ry = longint'(r.ry);
            ell_cx = longint'(r.cx);
            ell_cy = longint'(r.cy);
            rx2 = ell_rx * ell_rx;
            ry2 = ell_ry * ell_ry;
            ell_active = 1'b1;
            ell_region2 = 1'b0;
            ell_x = 0;
            ell_y = ell_ry;
            ell_gx = 0;
            ell_gy = 2 * rx2 * ell_ry;
            ell_dec = 4 * ry2 + rx2 - 4 * rx2 * ell_ry;
            check_region_switch();
        end else if (ell_active) begin
            rx2 = ell_rx * ell_rx;
            ry2 = ell_ry * ell_ry;
            x0 = ell_x;
            y0 = ell_y;
            if (!ell_region2) begin
                ell_x = ell_x + 1;
                ell_gx = ell_gx + 2 * ry2;
                if (ell_dec < 0) begin
                    ell_dec = ell_dec + 4 * ell_gx + 4 * ry2;
                end else begin
                    ell_y = ell_y - 1;
                    ell_gy = ell_gy - 2 * rx2;
                    ell_dec = ell_dec + 4 * ell_gx - 4 * ell_gy + 4 * ry2;
                end
            end else begin
                ell_y = ell_y - 1;
                ell_gy = ell_gy - 2 * rx2;
                if (ell_dec > 0) begin
                    ell_dec = ell_dec + 4 * rx2 - 4 * ell_gy;
                end else begin
                    ell_x = ell_x + 1;
                    ell_gx = ell_gx + 2 * ry2;
                    ell_dec = ell_dec + 4 * ell_gx - 4 * ell_gy + 4 * rx2;
                end
            end
            check_region_switch();
            sx[0] = ell_cx + x0;  sy[0] = ell_cy + y0;
            sx[1] = ell_cx - x0;  sy[1] = ell_cy + y0;
            sx[2] = ell_cx + x0;  sy[2] = ell_cy - y0;
            sx[3] = ell_cx - x0;  sy[3] = ell_cy - y0;
            for (int i = 0; i < GROUP_LEN; i++) begin
                group_buf[i].x = sx[i][PIX_W-1:0];
                group_buf[i].y = sy[i][PIX_W-1:0];
                group_buf[i].last = (i == GROUP_LEN - 1);
                group_buf[i].done = !ell_active;
            end
            group_len = GROUP_LEN;
        end
    endtask

    always @(posedge clk) begin : monitor
        pixel_t want;
        pixel_t fixed_px;
        if (rst_n) begin
            if (pixel_strobe) begin
                if (pixels_due.size() == 0) begin
                    $error("unexpected pixel (%0d, %0d)", pixel_x, pixel_y);
                    mismatches++;
                end else begin
                    want = pixels_due.pop_front();
                    if (pixel_x !== $signed(want.x)) begin
                        $error("pixel_x: expected %0d, got %0d", $signed(want.x), pixel_x);
                        mismatches++;
                    end
                    if (pixel_y !== $signed(want.y)) begin
                        $error("pixel_y: expected %0d, got %0d", $signed(want.y), pixel_y);
                        mismatches++;
                    end
                    if (last_of_step !== want.last) begin
                        $error("last_of_step: expected %0b, got %0b", want.last, last_of_step);
                        mismatches++;
                    end
                    if (ellipse_done !== want.done) begin
                        $error("ellipse_done: expected %0b, got %0b", want.done, ellipse_done);
                        mismatches++;
                    end
                end
            end
            if (start && !busy) begin
                trace_ellipse(drv);
                if (drv.typed) begin
                    for (int i = 0; i < int'(drv.n_typed); i++) begin
                        fixed_px.x = drv.tx;
                        fixed_px.y = drv.ty;
                        fixed_px.last = (i == GROUP_LEN - 1);
                        fixed_px.done = drv.tdone;
                        pixels_due.push_back(fixed_px);
                    end
                end else begin
                    for (int i = 0; i < group_len; i++)
                        pixels_due.push_back(group_buf[i]);
                end
            end
            if (pixel_strobe || (start && !busy)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // sender gap, with occasional back-to-back stretches
    function automatic int pick_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = int'($urandom_range(5, 30));
            return 0;
        end
        return int'($urandom_range(0, 16));
    endfunction

    // called right after a rising edge; returns at the edge of the transfer
    task automatic send_item(input stim_row_t r);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        drv <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent++;
    endtask

    function automatic stim_row_t mk_row(logic o, int rx, int ry, int cx, int cy,
                                         logic typed, int nt, int px, int py, logic pd);
        stim_row_t r;
        r.op = o;
        r.rx = RB'(rx);
        r.ry = RB'(ry);
        r.cx = CB'(cx);
        r.cy = CB'(cy);
        r.typed = typed;
        r.n_typed = 3'(nt);
        r.tx = PIX_W'(px);
        r.ty = PIX_W'(py);
        r.tdone = pd;
        return r;
    endfunction

    function automatic stim_row_t rand_step();
        stim_row_t r;
        r = '0;
        r.op = OP_STEP;
        r.rx = RB'($urandom);
        r.ry = RB'($urandom);
        r.cx = CB'($urandom);
        r.cy = CB'($urandom);
        return r;
    endfunction

    initial begin : stimulus
        stim_row_t r;
        int n_steps;
        logic big;

        // step while idle, zero radii, coordinate extremes, abandon while running
        dir_tab[0]  = mk_row(OP_STEP,  1023, 1023, 2047, 2047, 1, 0, 0, 0, 0);
        dir_tab[1]  = mk_row(OP_START, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        dir_tab[2]  = mk_row(OP_STEP,  0, 0, 0, 0, 1, 4, 0, 0, 1);
        dir_tab[3]  = mk_row(OP_STEP,  0, 0, 0, 0, 1, 0, 0, 0, 0);
        dir_tab[4]  = mk_row(OP_START, 0, 0, 2047, 2047, 1, 0, 0, 0, 0);
        dir_tab[5]  = mk_row(OP_STEP,  1023, 0, 0, 1023, 1, 4, 2047, 2047, 1);
        dir_tab[6]  = mk_row(OP_START, 1023, 0, 1024, 1024, 1, 0, 0, 0, 0);
        dir_tab[7]  = mk_row(OP_STEP,  0, 0, 0, 0, 1, 4, 1024, 1024, 1);
        dir_tab[8]  = mk_row(OP_STEP,  0, 0, 0, 0, 1, 0, 0, 0, 0);
        dir_tab[9]  = mk_row(OP_START, 0, 3, 100, 200, 0, 0, 0, 0, 0);
        for (int i = 10; i < 15; i++)
            dir_tab[i] = mk_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_tab[15] = mk_row(OP_START, 1023, 1023, 2047, 0, 0, 0, 0, 0, 0);
        for (int i = 16; i < 19; i++)
            dir_tab[i] = mk_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_tab[19] = mk_row(OP_START, 3, 2, 5, 5, 0, 0, 0, 0, 0);
        for (int i = 20; i < DIR_ROWS; i++)
            dir_tab[i] = mk_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_tab[i]);

        while (items_sent < TOTAL_ITEMS) begin
            if ($urandom_range(0, 6) == 0) begin
                // lone item of either kind, any field values
                r = rand_step();
                r.op = 1'($urandom_range(0, 1));
                send_item(r);
            end else begin
                big = ($urandom_range(0, 7) == 0);
                r = '0;
                r.op = OP_START;
                r.rx = big ? RB'($urandom_range(0, 1023)) : RB'($urandom_range(0, 15));
                r.ry = big ? RB'($urandom_range(0, 1023)) : RB'($urandom_range(0, 15));
                r.cx = CB'($urandom_range(0, 2047));
                r.cy = CB'($urandom_range(0, 2047));
                send_item(r);
                // small ones usually run to the end and a little past it
                n_steps = big ? int'($urandom_range(3, 24))
                              : int'(r.rx) + int'(r.ry) + 2 + int'($urandom_range(0, 3));
                if ($urandom_range(0, 5) == 0)
                    n_steps = int'($urandom_range(1, n_steps));
                repeat (n_steps) send_item(rand_step());
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pixels_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/mer_pkg.sv
src/mer_front.sv
src/mer_mult.sv
src/mer_engine.sv
src/mer_emit.sv
src/midpoint_ellipse_rasterizer_core.sv
src/mer_checker.sv
verif/tb.sv
